FILE: design/rxr_pkg.sv
`default_nettype none
package rxr_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_W        = 32;
	localparam int TEX_BITS      = 16;
	localparam int TEX_W         = TEX_BITS + 1;
	localparam int CFG_ADDR_W    = 5;
	localparam int CFG_IDX_W     = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PLANE_Y = 3'd0,
		REG_X_LOW   = 3'd1,
		REG_X_HIGH  = 3'd2,
		REG_Z_LOW   = 3'd3,
		REG_Z_HIGH  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] plane_y;
		logic signed [WORD_W-1:0] x_low;
		logic signed [WORD_W-1:0] x_high;
		logic signed [WORD_W-1:0] z_low;
		logic signed [WORD_W-1:0] z_high;
	} cfg_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] origin_x;
		logic signed [WORD_W-1:0] origin_y;
		logic signed [WORD_W-1:0] origin_z;
		logic signed [WORD_W-1:0] dir_x;
		logic signed [WORD_W-1:0] dir_y;
		logic signed [WORD_W-1:0] dir_z;
		logic signed [WORD_W-1:0] t_min;
		logic signed [WORD_W-1:0] t_max;
	} ray_in_t;

	typedef struct packed {
		logic                     hit;
		logic signed [WORD_W-1:0] hit_t;
		logic [TEX_W-1:0]         tex_u;
		logic [TEX_W-1:0]         tex_v;
		logic                     front_face;
		logic                     normal_down;
		logic signed [WORD_W-1:0] point_x;
		logic signed [WORD_W-1:0] point_y;
		logic signed [WORD_W-1:0] point_z;
	} ray_out_t;

	// sideband through the t divider
	typedef struct packed {
		ray_in_t ray;
		logic    dy_zero;
		logic    neg;
	} tdiv_sb_t;

	// sideband through the u texture divider
	typedef struct packed {
		logic              miss;
		logic              zw_u;
		logic              dy_neg;
		logic [WORD_W-1:0] t;
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] z;
	} tail_t;

endpackage
`default_nettype wire

FILE: design/rxr_div_pipe.sv
`default_nettype none
// Unsigned restoring divider, one quotient bit per stage.
// Expects num >> Q_W < den so that Q_W quotient bits suffice.
module rxr_div_pipe #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 32,
	parameter int Q_W   = 17,
	parameter int SB_W  = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	input  wire logic [SB_W-1:0]  side,
	output logic                  out_valid,
	output logic [Q_W-1:0]        quo,
	output logic [SB_W-1:0]       out_side
);

	logic             v_s   [Q_W];
	logic [DEN_W-1:0] rem_s [Q_W];
	logic [Q_W-1:0]   lo_s  [Q_W];
	logic [Q_W-1:0]   quo_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];
	logic [SB_W-1:0]  sb_s  [Q_W];

	logic [DEN_W+NUM_W-1:0] num_ext;
	assign num_ext = {{DEN_W{1'b0}}, num};

	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		logic             pv;
		logic [DEN_W-1:0] prem;
		logic [DEN_W-1:0] pden;
		logic [Q_W-1:0]   plo;
		logic [Q_W-1:0]   pquo;
		logic [SB_W-1:0]  psb;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;

		if (i == 0) begin : g_first
			assign pv   = in_valid;
			assign prem = num_ext[Q_W +: DEN_W];
			assign plo  = num[Q_W-1:0];
			assign pquo = '0;
			assign pden = den;
			assign psb  = side;
		end else begin : g_next
			assign pv   = v_s[i-1];
			assign prem = rem_s[i-1];
			assign plo  = lo_s[i-1];
			assign pquo = quo_s[i-1];
			assign pden = den_s[i-1];
			assign psb  = sb_s[i-1];
		end

		assign trial = {prem, plo[Q_W-1]};
		assign diff  = trial - {1'b0, pden};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[DEN_W]) begin
					rem_s[i] <= diff[DEN_W-1:0];
					quo_s[i] <= {pquo[Q_W-2:0], 1'b1};
				end else begin
					rem_s[i] <= trial[DEN_W-1:0];
					quo_s[i] <= {pquo[Q_W-2:0], 1'b0};
				end
				lo_s[i]  <= {plo[Q_W-2:0], 1'b0};
				den_s[i] <= pden;
				sb_s[i]  <= psb;
			end
		end
	end

	assign out_valid = v_s[Q_W-1];
	assign quo       = quo_s[Q_W-1];
	assign out_side  = sb_s[Q_W-1];

endmodule
`default_nettype wire

FILE: design/rxr_cfg.sv
`default_nettype none
module rxr_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [rxr_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [rxr_pkg::WORD_W-1:0]     pwdata,
	output logic [rxr_pkg::WORD_W-1:0]          prdata,
	output logic                                pready,
	output rxr_pkg::cfg_t                       cfg
);

	rxr_pkg::cfg_t     cfg_q;
	rxr_pkg::cfg_reg_t idx;

	assign idx    = rxr_pkg::cfg_reg_t'(paddr[rxr_pkg::CFG_ADDR_W-1:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				rxr_pkg::REG_PLANE_Y: cfg_q.plane_y <= pwdata;
				rxr_pkg::REG_X_LOW:   cfg_q.x_low   <= pwdata;
				rxr_pkg::REG_X_HIGH:  cfg_q.x_high  <= pwdata;
				rxr_pkg::REG_Z_LOW:   cfg_q.z_low   <= pwdata;
				rxr_pkg::REG_Z_HIGH:  cfg_q.z_high  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			rxr_pkg::REG_PLANE_Y: prdata = cfg_q.plane_y;
			rxr_pkg::REG_X_LOW:   prdata = cfg_q.x_low;
			rxr_pkg::REG_X_HIGH:  prdata = cfg_q.x_high;
			rxr_pkg::REG_Z_LOW:   prdata = cfg_q.z_low;
			rxr_pkg::REG_Z_HIGH:  prdata = cfg_q.z_high;
			default:              prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

FILE: design/ray_xz_rect_intersect_top.sv
// Ray test against a rectangle in the plane y = plane_y, bounded in x and z. One ray per
// cycle enters while the output is not stalled, and one result per ray leaves, in order;
// the t divider works one bit per stage and the texture dividers have 17 stages. A
// stalled output freezes the whole pipeline; bubbles do not. A miss returns an all-zero
// result. The user writes registers over APB only while idle; the block does not enforce it.
`default_nettype none
module ray_xz_rect_intersect_top #(
	parameter int FRAC_BITS = rxr_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [rxr_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [rxr_pkg::WORD_W-1:0]     pwdata,
	output logic [rxr_pkg::WORD_W-1:0]          prdata,
	output logic                                pready,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire rxr_pkg::ray_in_t               in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output rxr_pkg::ray_out_t                   out_data
);

	localparam int TN_W = 33 + FRAC_BITS;      // |k - oy| << FRAC_BITS
	localparam int TS_W = TN_W + 1;            // signed t
	localparam int UN_W = 32 + rxr_pkg::TEX_BITS;

	rxr_pkg::cfg_t cfg;
	logic          en;

	rxr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic out_valid_q;
	rxr_pkg::ray_out_t out_q;

	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	// s1: register ray, plane distance
	logic              v_s1;
	rxr_pkg::ray_in_t  ray_s1;
	logic signed [32:0] diff_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1  <= in_data;
			diff_s1 <= {cfg.plane_y[31], cfg.plane_y} - {in_data.origin_y[31], in_data.origin_y};
		end
	end

	// s2: magnitudes for the divider
	logic                v_s2;
	logic [TN_W-1:0]     num_s2;
	logic [31:0]         den_s2;
	rxr_pkg::tdiv_sb_t   sb_s2;
	logic [32:0]         dmag;
	logic [32:0]         dymag;

	assign dmag  = diff_s1[32] ? 33'(-diff_s1) : 33'(diff_s1);
	assign dymag = ray_s1.dir_y[31] ? -{1'b1, ray_s1.dir_y} : {1'b0, ray_s1.dir_y};

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2        <= {dmag, {FRAC_BITS{1'b0}}};
			den_s2        <= dymag[31:0];
			sb_s2.ray     <= ray_s1;
			sb_s2.dy_zero <= (ray_s1.dir_y == '0);
			sb_s2.neg     <= diff_s1[32] ^ ray_s1.dir_y[31];
		end
	end

	logic              v_td;
	logic [TN_W-1:0]   q_td;
	rxr_pkg::tdiv_sb_t sb_td;

	rxr_div_pipe #(
		.NUM_W (TN_W),
		.DEN_W (32),
		.Q_W   (TN_W),
		.SB_W  ($bits(rxr_pkg::tdiv_sb_t))
	) u_tdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.num       (num_s2),
		.den       (den_s2),
		.side      (sb_s2),
		.out_valid (v_td),
		.quo       (q_td),
		.out_side  (sb_td)
	);

	// s3: signed t
	logic               v_s3;
	logic signed [TS_W-1:0] t_s3;
	rxr_pkg::ray_in_t   ray_s3;
	logic               dyz_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s3   <= sb_td.neg ? -$signed({1'b0, q_td}) : $signed({1'b0, q_td});
			ray_s3 <= sb_td.ray;
			dyz_s3 <= sb_td.dy_zero;
		end
	end

	// s4: window test on the wide quotient
	logic              v_s4;
	logic signed [31:0] t_s4;
	rxr_pkg::ray_in_t  ray_s4;
	logic              miss_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s4    <= t_s3[31:0];
			ray_s4  <= ray_s3;
			miss_s4 <= dyz_s3 || (t_s3 < TS_W'(ray_s3.t_min)) || (t_s3 > TS_W'(ray_s3.t_max));
		end
	end

	// s5: products
	logic               v_s5;
	logic signed [63:0] px_s5, py_s5, pz_s5;
	logic signed [31:0] t_s5;
	rxr_pkg::ray_in_t   ray_s5;
	logic               miss_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s5   <= 64'(t_s4) * 64'(ray_s4.dir_x);
			py_s5   <= 64'(t_s4) * 64'(ray_s4.dir_y);
			pz_s5   <= 64'(t_s4) * 64'(ray_s4.dir_z);
			t_s5    <= t_s4;
			ray_s5  <= ray_s4;
			miss_s5 <= miss_s4;
		end
	end

	// s6: hit point, floor via arithmetic shift
	logic               v_s6;
	logic signed [64:0] x_s6, y_s6, z_s6;
	logic signed [31:0] t_s6;
	logic               dyneg_s6;
	logic               miss_s6;
	logic signed [63:0] shx, shy, shz;

	assign shx = px_s5 >>> FRAC_BITS;
	assign shy = py_s5 >>> FRAC_BITS;
	assign shz = pz_s5 >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s6     <= 65'(ray_s5.origin_x) + 65'(shx);
			y_s6     <= 65'(ray_s5.origin_y) + 65'(shy);
			z_s6     <= 65'(ray_s5.origin_z) + 65'(shz);
			t_s6     <= t_s5;
			dyneg_s6 <= ray_s5.dir_y[31];
			miss_s6  <= miss_s5;
		end
	end

	// s7: bounds, saturation, texture operands
	logic               v_s7;
	rxr_pkg::tail_t     tail_s7;
	logic               zwv_s7;
	logic [UN_W-1:0]    nu_s7, nv_s7;
	logic [31:0]        du_s7, dv_s7;
	logic signed [32:0] offu, offv, wu, wv;
	logic               zwu, zwv, oob;
	logic signed [31:0] ysat;

	assign offu = {x_s6[31], x_s6[31:0]} - {cfg.x_low[31], cfg.x_low};
	assign offv = {z_s6[31], z_s6[31:0]} - {cfg.z_low[31], cfg.z_low};
	assign wu   = {cfg.x_high[31], cfg.x_high} - {cfg.x_low[31], cfg.x_low};
	assign wv   = {cfg.z_high[31], cfg.z_high} - {cfg.z_low[31], cfg.z_low};
	assign zwu  = wu[32] || (wu == '0);
	assign zwv  = wv[32] || (wv == '0);
	assign oob  = (x_s6 < 65'(cfg.x_low)) || (x_s6 > 65'(cfg.x_high)) ||
	              (z_s6 < 65'(cfg.z_low)) || (z_s6 > 65'(cfg.z_high));

	always_comb begin
		if (y_s6 > 65'sh0_7FFF_FFFF) begin
			ysat = 32'sh7FFF_FFFF;
		end else if (y_s6 < -65'sh0_8000_0000) begin
			ysat = 32'sh8000_0000;
		end else begin
			ysat = y_s6[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tail_s7.miss   <= miss_s6 || oob;
			tail_s7.zw_u   <= zwu;
			tail_s7.dy_neg <= dyneg_s6;
			tail_s7.t      <= t_s6;
			tail_s7.x      <= x_s6[31:0];
			tail_s7.y      <= ysat;
			tail_s7.z      <= z_s6[31:0];
			zwv_s7         <= zwv;
			nu_s7          <= {offu[31:0], {rxr_pkg::TEX_BITS{1'b0}}};
			nv_s7          <= {offv[31:0], {rxr_pkg::TEX_BITS{1'b0}}};
			du_s7          <= zwu ? 32'd1 : wu[31:0];
			dv_s7          <= zwv ? 32'd1 : wv[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_td;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	logic                       v_u, v_v;
	logic [rxr_pkg::TEX_W-1:0]  q_u, q_v;
	rxr_pkg::tail_t             tail_u;
	logic                       zwv_v;

	rxr_div_pipe #(
		.NUM_W (UN_W),
		.DEN_W (32),
		.Q_W   (rxr_pkg::TEX_W),
		.SB_W  ($bits(rxr_pkg::tail_t))
	) u_udiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.num       (nu_s7),
		.den       (du_s7),
		.side      (tail_s7),
		.out_valid (v_u),
		.quo       (q_u),
		.out_side  (tail_u)
	);

	rxr_div_pipe #(
		.NUM_W (UN_W),
		.DEN_W (32),
		.Q_W   (rxr_pkg::TEX_W),
		.SB_W  (1)
	) u_vdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.num       (nv_s7),
		.den       (dv_s7),
		.side      (zwv_s7),
		.out_valid (v_v),
		.quo       (q_v),
		.out_side  (zwv_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_u && v_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (tail_u.miss) begin
				out_q <= '0;
			end else begin
				out_q.hit         <= 1'b1;
				out_q.hit_t       <= tail_u.t;
				out_q.tex_u       <= tail_u.zw_u ? '0 : q_u;
				out_q.tex_v       <= zwv_v ? '0 : q_v;
				out_q.front_face  <= tail_u.dy_neg;
				out_q.normal_down <= !tail_u.dy_neg;
				out_q.point_x     <= tail_u.x;
				out_q.point_y     <= tail_u.y;
				out_q.point_z     <= tail_u.z;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data == '0)
		else $error("miss result not cleared");

	a_face: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit |-> out_data.front_face != out_data.normal_down)
		else $error("face and normal disagree");

	a_tex_u: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit |-> out_data.tex_u <= 17'd65536)
		else $error("tex_u above one");

	a_tex_v: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit |-> out_data.tex_v <= 17'd65536)
		else $error("tex_v above one");

endmodule
`default_nettype wire

FILE: verif/ray_xz_rect_intersect_top_tb.sv
module ray_xz_rect_intersect_top_tb;

	localparam int     FRAC       = rxr_pkg::FRAC_BITS_DEF;
	localparam int     DRAIN_WAIT = 100;
	localparam int     CYCLE_CAP  = 400000;
	localparam longint W_MIN      = -64'sd2147483648;
	localparam longint W_MAX      = 64'sd2147483647;

	class rect_hit_board;
		logic signed [rxr_pkg::WORD_W-1:0] plane_y, x_low, x_high, z_low, z_high;
		rxr_pkg::ray_out_t expected_hits[$];
		int mismatches;
		int transfers;
		int hits;

		function void set_reg(rxr_pkg::cfg_reg_t idx, logic [rxr_pkg::WORD_W-1:0] val);
			case (idx)
				rxr_pkg::REG_PLANE_Y: plane_y = val;
				rxr_pkg::REG_X_LOW:   x_low = val;
				rxr_pkg::REG_X_HIGH:  x_high = val;
				rxr_pkg::REG_Z_LOW:   z_low = val;
				rxr_pkg::REG_Z_HIGH:  z_high = val;
				default: ;
			endcase
		endfunction

		function longint sat_word(longint v);
			if (v > W_MAX)
				return W_MAX;
			if (v < W_MIN)
				return W_MIN;
			return v;
		endfunction

		function logic [rxr_pkg::TEX_W-1:0] tex_of(longint pos, longint lo, longint hi);
			longint w;
			w = hi - lo;
			if (w <= 0)
				return '0;
			return rxr_pkg::TEX_W'(((pos - lo) * (64'sd1 <<< rxr_pkg::TEX_BITS)) / w);
		endfunction

		function rxr_pkg::ray_out_t predict_hit(rxr_pkg::ray_in_t r);
			rxr_pkg::ray_out_t o;
			longint k, oy, dy, t, x, z, xl, xh, zl, zh;
			o = '0;
			k = plane_y;
			oy = r.origin_y;
			dy = r.dir_y;
			xl = x_low;
			xh = x_high;
			zl = z_low;
			zh = z_high;
			if (dy == 0)
				return o;
			t = ((k - oy) * (64'sd1 <<< FRAC)) / dy;
			if (t < longint'(r.t_min) || t > longint'(r.t_max))
				return o;
			// floor of the product, the shift is arithmetic
			x = longint'(r.origin_x) + ((t * longint'(r.dir_x)) >>> FRAC);
			z = longint'(r.origin_z) + ((t * longint'(r.dir_z)) >>> FRAC);
			if (x < xl || x > xh || z < zl || z > zh)
				return o;
			o.hit = 1'b1;
			o.hit_t = t[rxr_pkg::WORD_W-1:0];
			o.tex_u = tex_of(x, xl, xh);
			o.tex_v = tex_of(z, zl, zh);
			o.front_face = dy < 0;
			o.normal_down = !(dy < 0);
			o.point_x = x[rxr_pkg::WORD_W-1:0];
			o.point_y = rxr_pkg::WORD_W'(sat_word(oy + ((t * dy) >>> FRAC)));
			o.point_z = z[rxr_pkg::WORD_W-1:0];
			return o;
		endfunction

		function void note_ray(rxr_pkg::ray_in_t r);
			expected_hits.push_back(predict_hit(r));
		endfunction

		function void check_result(rxr_pkg::ray_out_t got);
			rxr_pkg::ray_out_t want;
			transfers++;
			if (expected_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: %p", got);
				return;
			end
			want = expected_hits.pop_front();
			if (want.hit)
				hits++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch:\n  expected %p\n  actual   %p", want, got);
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           psel, penable, pwrite;
	logic [rxr_pkg::CFG_ADDR_W-1:0] paddr;
	logic [rxr_pkg::WORD_W-1:0]     pwdata;
	logic [rxr_pkg::WORD_W-1:0]     prdata;
	logic                           pready;
	logic                           in_valid;
	logic                           in_stall;
	rxr_pkg::ray_in_t               in_data;
	logic                           out_valid;
	logic                           out_stall;
	rxr_pkg::ray_out_t              out_data;

	rect_hit_board board = new();
	int send_idle_pct;
	int stall_pct;
	int cycles;

	ray_xz_rect_intersect_top u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("ray_xz_rect_intersect_top regression: fail");
			$finish;
		end
	end

	// result side: sample at negedge, transfer at the next rising edge
	initial begin : result_side
		logic              v, s;
		rxr_pkg::ray_out_t d;
		forever begin
			@(negedge clk);
			v = out_valid;
			s = out_stall;
			d = out_data;
			@(posedge clk);
			if (arst_n && v && !s)
				board.check_result(d);
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic cfg_write(rxr_pkg::cfg_reg_t idx, logic [rxr_pkg::WORD_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		board.set_reg(idx, val);
	endtask

	task automatic set_rect(logic [rxr_pkg::WORD_W-1:0] k, logic [rxr_pkg::WORD_W-1:0] xl,
			logic [rxr_pkg::WORD_W-1:0] xh, logic [rxr_pkg::WORD_W-1:0] zl,
			logic [rxr_pkg::WORD_W-1:0] zh);
		cfg_write(rxr_pkg::REG_PLANE_Y, k);
		cfg_write(rxr_pkg::REG_X_LOW, xl);
		cfg_write(rxr_pkg::REG_X_HIGH, xh);
		cfg_write(rxr_pkg::REG_Z_LOW, zl);
		cfg_write(rxr_pkg::REG_Z_HIGH, zh);
	endtask

	task automatic send_ray(rxr_pkg::ray_in_t r);
		logic s;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do begin
			@(negedge clk);
			s = in_stall;
			@(posedge clk);
		end while (s);
		board.note_ray(r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.expected_hits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic rxr_pkg::ray_in_t mk(longint ox, longint oy, longint oz, longint dx,
			longint dy, longint dz, longint tmin, longint tmax);
		rxr_pkg::ray_in_t r;
		r.origin_x = ox[31:0];
		r.origin_y = oy[31:0];
		r.origin_z = oz[31:0];
		r.dir_x = dx[31:0];
		r.dir_y = dy[31:0];
		r.dir_z = dz[31:0];
		r.t_min = tmin[31:0];
		r.t_max = tmax[31:0];
		return r;
	endfunction

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return 32'($signed($urandom_range(262143)) - 131072);
			default: return $urandom;
		endcase
	endfunction

	function automatic longint pick_in(longint lo, longint hi);
		longint unsigned span, rr;
		span = hi - lo + 1;
		rr = {$urandom, $urandom};
		return lo + longint'(rr % span);
	endfunction

	// a ray built to cross the plane inside the rectangle, with a window around its t or just above or below it
	function automatic rxr_pkg::ray_in_t aimed_ray();
		longint k, oy, dy, t, tx, tz, dx, dz, ox, oz, tmin, tmax;
		k = board.plane_y;
		oy = k + $signed($urandom_range(1048575)) - 524288;
		if (oy > W_MAX || oy < W_MIN)
			oy = k;
		dy = $urandom_range(1, 262144);
		if ($urandom_range(1))
			dy = -dy;
		t = ((k - oy) * (64'sd1 <<< FRAC)) / dy;
		tx = pick_in(board.x_low, board.x_high);
		tz = pick_in(board.z_low, board.z_high);
		dx = $signed($urandom_range(262143)) - 131072;
		dz = $signed($urandom_range(262143)) - 131072;
		ox = tx - ((t * dx) >>> FRAC);
		oz = tz - ((t * dz) >>> FRAC);
		if (ox > W_MAX || ox < W_MIN) begin
			dx = 0;
			ox = tx;
		end
		if (oz > W_MAX || oz < W_MIN) begin
			dz = 0;
			oz = tz;
		end
		case ($urandom_range(5))
			0: begin tmin = t; tmax = t; end
			1: begin tmin = t + 1; tmax = W_MAX; end
			2: begin tmin = W_MIN; tmax = t - 1; end
			default: begin
				tmin = t - $urandom_range(65536);
				tmax = t + $urandom_range(65536);
			end
		endcase
		return mk(ox, oy, oz, dx, dy, dz, board.sat_word(tmin), board.sat_word(tmax));
	endfunction

	task automatic random_rays(int n, int idle_mode);
		rxr_pkg::ray_in_t r;
		case (idle_mode)
			0: begin send_idle_pct = 0; stall_pct = 0; end
			1: begin send_idle_pct = 75; stall_pct = 0; end
			2: begin send_idle_pct = 0; stall_pct = 75; end
			default: begin send_idle_pct = 31; stall_pct = 31; end
		endcase
		for (int i = 0; i < n; i++) begin
			if (board.x_high >= board.x_low && board.z_high >= board.z_low
					&& $urandom_range(99) < 75)
				r = aimed_ray();
			else
				r = mk(rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(),
					rnd_word(), rnd_word(), rnd_word());
			send_ray(r);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		cycles = 0;
		board.set_reg(rxr_pkg::REG_PLANE_Y, '0);
		board.set_reg(rxr_pkg::REG_X_LOW, '0);
		board.set_reg(rxr_pkg::REG_X_HIGH, '0);
		board.set_reg(rxr_pkg::REG_Z_LOW, '0);
		board.set_reg(rxr_pkg::REG_Z_HIGH, '0);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: a point rectangle at the origin, zero width both ways
		send_ray(mk(0, 32'h10000, 0, 0, -32'sh10000, 0, 0, W_MAX));
		send_ray(mk(0, 32'h10000, 0, 32'h10000, -32'sh10000, 0, 0, W_MAX));
		drain();

		set_rect(32'h10000, -32'sh20000, 32'h20000, -32'sh20000, 32'h20000);
		send_ray(mk(0, 32'h30000, 0, 32'h1234, 0, 32'h777, W_MIN, W_MAX));
		send_ray(mk(0, 32'h30000, 0, 0, -32'sh10000, 0, 0, W_MAX));
		send_ray(mk(32'h8000, -32'sh10000, -32'sh4000, 0, 32'h8000, 0, 0, W_MAX));
		send_ray(mk(0, 32'h30000, 0, 0, -32'sh10000, 0, 32'h30000, 32'h10000));
		send_ray(mk(-32'sh20000, 32'h30000, 32'h20000, 0, -32'sh10000, 0, 0, W_MAX));
		send_ray(mk(32'h20001, 32'h30000, 0, 0, -32'sh10000, 0, 0, W_MAX));
		send_ray(mk(0, 32'h30000, -32'sh20001, 0, -32'sh10000, 0, 0, W_MAX));
		send_ray(mk(-32'sh10000, 32'h30000, 0, 32'h8000, -32'sh10000, 32'h4000, 0, W_MAX));
		send_ray(mk(0, 32'h30000, 0, 0, -32'sh10000, 0, 32'h20000, 32'h20000));
		send_ray(mk(0, 32'h30000, 0, 0, 32'h10000, 0, W_MIN, 0));
		send_ray(mk(0, 32'h30000, 0, 0, 32'h10000, 0, 0, W_MAX));
		send_ray(mk(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN));
		send_ray(mk(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
		send_ray(mk(0, 0, 0, 0, 0, 0, 0, 0));
		send_ray(mk(-1, -1, -1, -1, -1, -1, -1, -1));
		send_ray(mk(0, 32'h30000, 0, 0, -1, 0, W_MIN, W_MAX));
		drain();

		random_rays(75, 0);
		set_rect(W_MIN[31:0], W_MIN[31:0], W_MAX[31:0], W_MIN[31:0], W_MAX[31:0]);
		send_ray(mk(0, W_MAX, 0, 0, W_MIN, 0, W_MIN, W_MAX));
		random_rays(75, 1);
		set_rect(W_MAX[31:0], -32'sh100, 32'h7fff0000, 32'h5000, 32'h5000);
		random_rays(75, 2);
		set_rect($urandom, -32'sh3000000, 32'h2000000, -32'sh1000000, 32'h4000000);
		random_rays(75, 3);
		// inverted bounds: nothing can hit
		set_rect(32'h40000, 32'h10000, -32'sh10000, 32'h10000, -32'sh10000);
		random_rays(60, 0);
		set_rect(-32'sh5000, -32'sh8000, 32'h8000, -32'sh8000, 32'h8000);
		random_rays(90, 3);

		$display("%0d ray transfers checked, %0d hits, over 7 rectangle settings",
			board.transfers, board.hits);
		$display("idling: none, sender gaps, result stalls, both together");
		if (board.mismatches == 0 && board.expected_hits.size() == 0)
			$display("ray_xz_rect_intersect_top regression: pass");
		else
			$display("ray_xz_rect_intersect_top regression: fail");
		$finish;
	end

endmodule
